// ===== design/cgfr_pkg.sv =====
// shared constants, codes and crc step for the gap-framed crc receiver
package cgfr_pkg;

    localparam logic [7:0]  MAX_FRAME_BYTES = 8'd128;
    localparam logic [15:0] CRC_POLY        = 16'h8005;
    localparam logic [15:0] CRC_START       = 16'hFFFF;
    localparam logic [7:0]  CODE_SET_POINT  = 8'h56;
    localparam logic [7:0]  CODE_READOUT    = 8'h49;
    localparam logic [7:0]  MIN_POS_FRAME   = 8'd6;
    localparam logic [7:0]  GAP_RESET       = 8'd10;
    localparam int          HEAD_DEPTH      = 4;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_POSITION   = 2'd0;
    localparam t_status ST_GOOD_OTHER = 2'd1;
    localparam t_status ST_BAD_CRC    = 2'd2;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== design/crc_checked_gap_frame_receiver_top.sv =====
// top level of the idle-gap framed receiver with crc-16 check
//
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_req_type, i_rx_byte
// result    out        o_valid / i_stall   o_frame_status, o_servo_id, o_position
// config    in         i_cfg_wr_en         i_cfg_wr_data (gap_ticks)
//
// one item per cycle unless the input stalls: an input register, then one pass of frame logic
// (eight-step crc fold or gap judgement) into the result register.
// a tick that ends a frame goes through the input register and then the result register to the outputs.
// synchronous active-low reset clears control and counters, and sets crc (ffff) and gap (10).
// input stalls only while an item waits and the result register is held.
module crc_checked_gap_frame_receiver_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_req_type,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_valid,
    input  logic                   i_stall,
    output cgfr_pkg::t_status      o_frame_status,
    output logic [7:0]             o_servo_id,
    output logic signed [11:0]     o_position,
    input  logic                   i_cfg_wr_en,
    input  logic [7:0]             i_cfg_wr_data
);
    import cgfr_pkg::*;

    logic        r_in_vld;
    logic        r_in_type;
    logic [7:0]  r_in_byte;

    logic [7:0]  r_gap;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_idle, n_idle;
    logic [7:0]  r_head [HEAD_DEPTH];

    logic        r_out_vld;
    t_status     r_out_status, n_out_status;
    logic [7:0]  r_out_id, n_out_id;
    logic [11:0] r_out_pos, n_out_pos;

    logic        out_free;
    logic        fire;
    logic        in_xfer;
    logic        n_result;
    logic        head_wr;

    assign out_free = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign in_xfer  = i_valid && !o_stall;

    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_idle       = r_idle;
        n_result     = 1'b0;
        n_out_status = ST_GOOD_OTHER;
        n_out_id     = 8'd0;
        n_out_pos    = 12'd0;
        head_wr      = 1'b0;
        if (r_in_type == REQ_BYTE) begin
            n_idle = 8'd0;
            if (r_byte_count < MAX_FRAME_BYTES) begin
                head_wr      = r_byte_count < 8'(HEAD_DEPTH);
                n_byte_count = r_byte_count + 8'd1;
                n_crc        = crc_fold(r_crc, r_in_byte);
            end
        end else if (r_idle < r_gap) begin
            n_idle = r_idle + 8'd1;
            if (n_idle == r_gap) begin
                n_byte_count = 8'd0;
                n_crc        = CRC_START;
                if (r_byte_count != 8'd0) begin
                    n_result = 1'b1;
                    if (r_crc != 16'd0) begin
                        n_out_status = ST_BAD_CRC;
                    end else if (r_byte_count >= MIN_POS_FRAME &&
                                 (r_head[0] == CODE_SET_POINT ||
                                  r_head[0] == CODE_READOUT)) begin
                        n_out_status = ST_POSITION;
                        n_out_id     = r_head[1];
                        n_out_pos    = {r_head[2][3:0], r_head[3]};
                    end else begin
                        n_out_status = ST_GOOD_OTHER;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_type <= i_req_type;
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_gap <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 8'd0;
            r_crc        <= CRC_START;
            r_idle       <= 8'd0;
        end else if (fire) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_idle       <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && head_wr) begin
            r_head[r_byte_count[1:0]] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= fire && n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_result) begin
            r_out_status <= n_out_status;
            r_out_id     <= n_out_id;
            r_out_pos    <= n_out_pos;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_frame_status = r_out_status;
    assign o_servo_id     = r_out_id;
    assign o_position     = r_out_pos;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= MAX_FRAME_BYTES)
        else $error("frame byte count above maximum");

    a_restart_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_result |=> r_byte_count == 8'd0 && r_crc == CRC_START)
        else $error("frame state not restarted after a result");

    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_result |-> r_in_type == REQ_TICK && r_byte_count != 8'd0)
        else $error("result from a byte or an empty frame");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld && i_stall)
        else $error("input stalled without a held result");

    a_idle_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_type == REQ_BYTE |=> r_idle == 8'd0)
        else $error("idle counter not cleared by a byte");

endmodule
